// File: rtl/nfe_pkg.sv
package nfe_pkg;

  localparam int unsigned DUR_W     = 15;
  localparam int unsigned SYM_W     = 6;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [SYM_W-1:0] LEAD_SYM = 6'd0;
  localparam logic [SYM_W-1:0] LAST_SYM = 6'd33;

  typedef logic [DUR_W-1:0] dur_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEC_LEAD   = 3'd0,
    REG_LEAD_SPACE = 3'd1,
    REG_ALT_LEAD   = 3'd2,
    REG_BIT_MARK   = 3'd3,
    REG_ONE_SPACE  = 3'd4,
    REG_ZERO_SPACE = 3'd5,
    REG_STOP_MARK  = 3'd6
  } reg_idx_t;

  localparam dur_t RST_NEC_LEAD   = 15'd9000;
  localparam dur_t RST_LEAD_SPACE = 15'd4500;
  localparam dur_t RST_ALT_LEAD   = 15'd4500;
  localparam dur_t RST_BIT_MARK   = 15'd560;
  localparam dur_t RST_ONE_SPACE  = 15'd1690;
  localparam dur_t RST_ZERO_SPACE = 15'd560;
  localparam dur_t RST_STOP_MARK  = 15'd560;

  typedef struct packed {
    dur_t nec_lead_mark;
    dur_t lead_space;
    dur_t alt_lead_mark;
    dur_t bit_mark;
    dur_t one_space;
    dur_t zero_space;
    dur_t stop_mark;
  } cfg_regs_t;

  // one symbol request from the frame stage to the output stage
  typedef struct packed {
    logic [SYM_W-1:0] num;
    logic             alt;
    logic             data_bit;
  } sym_req_t;

  // lo, hi, cmd, ~cmd; short NEC address gets hi = ~lo
  function automatic logic [WORD_W-1:0] build_word(input logic [15:0] addr,
                                                   input logic [7:0]  cmd,
                                                   input logic        alt);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = addr[7:0];
    if (alt || (addr[15:8] != 8'h00)) begin
      hi = addr[15:8];
    end else begin
      hi = ~lo;
    end
    return {lo, hi, cmd, ~cmd};
  endfunction

endpackage

// File: rtl/nfe_if.sv
interface nfe_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] address;
  logic [7:0]  command;
  logic        action;

  modport source (output valid, output address, output command, output action, input ready);
  modport sink   (input valid, input address, input command, input action, output ready);
endinterface

interface nfe_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] mark_duration;
  logic        mark_level;
  logic [14:0] space_duration;
  logic        space_level;
  logic [5:0]  symbol_number;
  logic        last;

  modport source (output valid, output mark_duration, output mark_level,
                  output space_duration, output space_level,
                  output symbol_number, output last, input ready);
  modport sink   (input valid, input mark_duration, input mark_level,
                  input space_duration, input space_level,
                  input symbol_number, input last, output ready);
endinterface

// File: rtl/nfe_cfg.sv
module nfe_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [nfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nfe_pkg::DUR_W-1:0]          cfg_data,
  output nfe_pkg::cfg_regs_t                 regs
);
  import nfe_pkg::*;

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.nec_lead_mark <= RST_NEC_LEAD;
      regs_r.lead_space    <= RST_LEAD_SPACE;
      regs_r.alt_lead_mark <= RST_ALT_LEAD;
      regs_r.bit_mark      <= RST_BIT_MARK;
      regs_r.one_space     <= RST_ONE_SPACE;
      regs_r.zero_space    <= RST_ZERO_SPACE;
      regs_r.stop_mark     <= RST_STOP_MARK;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NEC_LEAD:   regs_r.nec_lead_mark <= cfg_data;
        REG_LEAD_SPACE: regs_r.lead_space    <= cfg_data;
        REG_ALT_LEAD:   regs_r.alt_lead_mark <= cfg_data;
        REG_BIT_MARK:   regs_r.bit_mark      <= cfg_data;
        REG_ONE_SPACE:  regs_r.one_space     <= cfg_data;
        REG_ZERO_SPACE: regs_r.zero_space    <= cfg_data;
        REG_STOP_MARK:  regs_r.stop_mark     <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign regs = regs_r;

endmodule

// File: rtl/nfe_frame.sv
module nfe_frame (
  input  logic              clk,
  input  logic              rst_n,
  nfe_in_if.sink            in_ch,
  output logic              req_valid,
  output nfe_pkg::sym_req_t req,
  input  logic              req_ready
);
  import nfe_pkg::*;

  logic              busy_r;
  logic [SYM_W-1:0]  sym_r;
  logic [WORD_W-1:0] word_r;
  logic              alt_r;
  logic              accept;
  logic              step;
  logic              at_last;

  assign at_last     = (sym_r == LAST_SYM);
  assign step        = busy_r && req_ready;
  // next frame may load while the stop symbol leaves
  assign in_ch.ready = !busy_r || (at_last && req_ready);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sym_r  <= LEAD_SYM;
    end else if (accept) begin
      busy_r <= 1'b1;
      sym_r  <= LEAD_SYM;
    end else if (step) begin
      busy_r <= !at_last;
      sym_r  <= sym_r + 6'd1;
    end
  end

  // data bits leave MSB first from the top of the shifter
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= build_word(in_ch.address, in_ch.command, in_ch.action);
      alt_r  <= in_ch.action;
    end else if (step && (sym_r != LEAD_SYM)) begin
      word_r <= {word_r[WORD_W-2:0], 1'b0};
    end
  end

  assign req_valid    = busy_r;
  assign req.num      = sym_r;
  assign req.alt      = alt_r;
  assign req.data_bit = word_r[WORD_W-1];

  a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (sym_r <= LAST_SYM))
    else $error("symbol counter past stop symbol");

  a_overlap_only_at_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && busy_r) |-> (at_last && step))
    else $error("new word taken mid-frame");

  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !at_last) |=> (busy_r && (sym_r == $past(sym_r) + 6'd1)))
    else $error("frame dropped before stop symbol");

endmodule

// File: rtl/nfe_symbol.sv
module nfe_symbol (
  input  logic               clk,
  input  logic               rst_n,
  input  nfe_pkg::cfg_regs_t regs,
  input  logic               req_valid,
  input  nfe_pkg::sym_req_t  req,
  output logic               req_ready,
  nfe_out_if.source          out_ch
);
  import nfe_pkg::*;

  logic             out_valid_r;
  dur_t             mark_r;
  dur_t             space_r;
  logic [SYM_W-1:0] num_r;
  logic             last_r;
  dur_t             mark_nxt;
  dur_t             space_nxt;
  logic             last_nxt;
  logic             load;

  assign req_ready = !out_valid_r || out_ch.ready;
  assign load      = req_valid && req_ready;

  always_comb begin
    mark_nxt  = regs.bit_mark;
    space_nxt = req.data_bit ? regs.one_space : regs.zero_space;
    last_nxt  = 1'b0;
    if (req.num == LEAD_SYM) begin
      mark_nxt  = req.alt ? regs.alt_lead_mark : regs.nec_lead_mark;
      space_nxt = regs.lead_space;
    end else if (req.num == LAST_SYM) begin
      mark_nxt  = regs.stop_mark;
      space_nxt = '0;
      last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_ready) begin
      out_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mark_r  <= mark_nxt;
      space_r <= space_nxt;
      num_r   <= req.num;
      last_r  <= last_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mark_duration  = mark_r;
  assign out_ch.mark_level     = 1'b1;
  assign out_ch.space_duration = space_r;
  assign out_ch.space_level    = 1'b0;
  assign out_ch.symbol_number  = num_r;
  assign out_ch.last           = last_r;

  a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == (num_r == LAST_SYM)))
    else $error("last flag out of step with symbol number");

  a_stop_no_space: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (space_r == '0))
    else $error("stop symbol carries a space");

endmodule

// File: rtl/ir_nec_frame_encoder.sv
// Pulse-distance IR frame encoder. Each input word (address, command, action)
// yields one frame of 34 output words: symbol 0 is the lead (mark from the
// NEC or alternate lead register, space from lead_space), symbols 1..32 carry
// the 32-bit frame word MSB first (bit_mark, then one_space or zero_space),
// and symbol 33 is the stop mark with a zero space and last set. The frame
// word is addr[7:0], addr[15:8], command, ~command; in NEC mode with an
// address of 0xFF or less the second byte is ~addr[7:0] instead. Durations
// are in ticks and come from seven 15-bit registers written through the cfg
// port (index 0..6 in list order; other indices are ignored; reset values
// 9000/4500/4500/560/1690/560/560). Rate: one output word per cycle while
// the sink takes every word; the symbol counter in the frame stage steps
// through the frame. The next input word is taken in the cycle the stop
// symbol moves to the output register, so frames follow with no gap. From
// input to the lead symbol a word passes the frame stage registers and then
// the output register. While the sink holds off, the output register keeps
// its word and the whole pipe stalls with it without loss. Configuration is
// sampled live, so write it only while no frame is in flight.
module ir_nec_frame_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  nfe_in_if.sink                        in_ch,
  nfe_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [nfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nfe_pkg::DUR_W-1:0]     cfg_data
);
  import nfe_pkg::*;

  cfg_regs_t regs;     // timing registers
  logic      req_valid;
  sym_req_t  req;      // symbol number, protocol, current data bit
  logic      req_ready;

  nfe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // input register: frame word shifter and symbol counter
  nfe_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  // duration select and output register
  nfe_symbol u_symbol (
    .clk       (clk),
    .rst_n     (rst_n),
    .regs      (regs),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .out_ch    (out_ch)
  );

endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nfe_pkg::*;

  // watchdog: cycles in a row with no word taken on either side
  localparam int unsigned STALL_LIMIT = 2000;
  // long sink hold-off that backs the encoder up into its input
  localparam int unsigned SQUEEZE_CYCLES = 400;
  // index past the last register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum int unsigned { PACE_NONE, PACE_FULL, PACE_SPARSE } pace_t;
  typedef enum int unsigned { CFG_ZERO, CFG_MAX, CFG_RAND } cfg_style_t;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  command;
    logic        action;
  } frame_req_t;

  typedef struct packed {
    dur_t             mark;
    logic             mark_lvl;
    dur_t             space;
    logic             space_lvl;
    logic [SYM_W-1:0] num;
    logic             last;
  } symbol_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // block inputs, all known from time zero
  logic                 in_valid = 1'b0;
  logic [15:0]          in_addr = '0;
  logic [7:0]           in_cmd = '0;
  logic                 in_act = 1'b0;
  logic                 out_rdy = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  dur_t                 cfg_data = '0;

  nfe_in_if  in_ch ();
  nfe_out_if out_ch ();

  assign in_ch.valid   = in_valid;
  assign in_ch.address = in_addr;
  assign in_ch.command = in_cmd;
  assign in_ch.action  = in_act;
  assign out_ch.ready  = out_rdy;

  ir_nec_frame_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench-side copy of the timing registers
  cfg_regs_t   tick;
  frame_req_t  req_q[$];
  symbol_t     frame_syms_q[$];

  pace_t       in_mode = PACE_FULL;
  pace_t       out_mode = PACE_FULL;
  logic        squeeze_req = 1'b0;
  logic        squeeze_done = 1'b0;

  int unsigned frames_queued = 0;
  int unsigned frames_in = 0;
  int unsigned words_out = 0;
  int unsigned settings = 0;
  int unsigned mismatches = 0;

  int unsigned in_gap = 0;
  int unsigned out_wait = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  frame_req_t  nxt_req;
  symbol_t     want_sym;

  function automatic int unsigned draw_wait(input pace_t mode);
    case (mode)
      PACE_FULL:   return $urandom_range(0, 16);
      PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
      default:     return 0;
    endcase
  endfunction

  // One frame: lead, 32 data symbols MSB first, stop. Word is
  // lo, hi, cmd, ~cmd; short NEC address folds ~lo into the hi byte.
  function automatic void encode_frame(input logic [15:0] addr, input logic [7:0] cmd,
                                       input logic alt);
    logic [7:0]  hi_byte;
    logic [31:0] frame_word;
    symbol_t     s;
    int          b;
    if (alt || addr > 16'h00FF) hi_byte = addr[15:8];
    else hi_byte = ~addr[7:0];
    frame_word  = {addr[7:0], hi_byte, cmd, ~cmd};
    s.mark_lvl  = 1'b1;
    s.space_lvl = 1'b0;
    s.mark      = alt ? tick.alt_lead_mark : tick.nec_lead_mark;
    s.space     = tick.lead_space;
    s.num       = LEAD_SYM;
    s.last      = 1'b0;
    frame_syms_q.push_back(s);
    for (b = 31; b >= 0; b--) begin
      s.mark  = tick.bit_mark;
      s.space = frame_word[b] ? tick.one_space : tick.zero_space;
      s.num   = SYM_W'(32 - b);
      frame_syms_q.push_back(s);
    end
    s.mark  = tick.stop_mark;
    s.space = '0;
    s.num   = LAST_SYM;
    s.last  = 1'b1;
    frame_syms_q.push_back(s);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want,
                           input logic [SYM_W-1:0] sym);
    if (got !== want)
      report_mismatch($sformatf("symbol %0d %s got %0d want %0d", sym, name, got, want));
  endtask

  // Driver: next word goes up once the current one is taken; the gap before
  // it only runs down while the block would take a word or no symbol is pending, so it shows as a bubble.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ch.ready) begin
        encode_frame(in_addr, in_cmd, in_act);
        frames_in++;
      end
      if (!in_valid || in_ch.ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          if (in_ch.ready || frame_syms_q.size() == 0) in_gap--;
        end else if (req_q.size() != 0) begin
          nxt_req = req_q.pop_front();
          in_valid <= 1'b1;
          in_addr  <= nxt_req.address;
          in_cmd   <= nxt_req.command;
          in_act   <= nxt_req.action;
          in_gap   = draw_wait(in_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off, once, while a frame is on its way out
  always @(posedge clk) begin
    if (squeeze_req && !squeeze_done && out_ch.valid) begin
      hold_left    <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each symbol word against the oldest prediction and
  // paces ready; the stall count only runs while a word is on offer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rdy <= 1'b0;
    end else begin
      if (out_ch.valid && out_rdy) begin
        words_out++;
        if (frame_syms_q.size() == 0) begin
          report_mismatch($sformatf("word for symbol %0d with nothing pending",
                                    out_ch.symbol_number));
        end else begin
          want_sym = frame_syms_q.pop_front();
          cmp_field("mark_duration", 16'(out_ch.mark_duration), 16'(want_sym.mark),
                    want_sym.num);
          cmp_field("mark_level", 16'(out_ch.mark_level), 16'(want_sym.mark_lvl),
                    want_sym.num);
          cmp_field("space_duration", 16'(out_ch.space_duration), 16'(want_sym.space),
                    want_sym.num);
          cmp_field("space_level", 16'(out_ch.space_level), 16'(want_sym.space_lvl),
                    want_sym.num);
          cmp_field("symbol_number", 16'(out_ch.symbol_number), 16'(want_sym.num),
                    want_sym.num);
          cmp_field("last", 16'(out_ch.last), 16'(want_sym.last), want_sym.num);
        end
        out_wait = draw_wait(out_mode);
      end else if (out_ch.valid && out_wait != 0) begin
        out_wait--;
      end
      if (hold_left != 0) begin
        out_rdy <= 1'b0;
      end else begin
        out_rdy <= (out_wait == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ch.ready) || (out_ch.valid && out_rdy)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic queue_frame(input logic [15:0] addr, input logic [7:0] cmd,
                             input logic alt);
    frame_req_t r;
    r.address = addr;
    r.command = cmd;
    r.action  = alt;
    req_q.push_back(r);
    frames_queued++;
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) begin
      queue_frame($urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                       : 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // all frames taken and every symbol seen, then a short settle
  task automatic drain();
    while (frames_in != frames_queued || frame_syms_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input dur_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_NEC_LEAD:   tick.nec_lead_mark = val;
      REG_LEAD_SPACE: tick.lead_space    = val;
      REG_ALT_LEAD:   tick.alt_lead_mark = val;
      REG_BIT_MARK:   tick.bit_mark      = val;
      REG_ONE_SPACE:  tick.one_space     = val;
      REG_ZERO_SPACE: tick.zero_space    = val;
      REG_STOP_MARK:  tick.stop_mark     = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input cfg_style_t style);
    reg_idx_t r;
    dur_t     v;
    r = REG_NEC_LEAD;
    repeat (7) begin
      case (style)
        CFG_ZERO: v = '0;
        CFG_MAX:  v = '1;
        default:  v = ($urandom_range(0, 3) == 0) ? dur_t'($urandom_range(0, 63))
                                                  : dur_t'($urandom_range(0, 32767));
      endcase
      write_reg(r, v);
      r = r.next();
    end
    settings++;
  endtask

  initial begin
    int ph;
    tick.nec_lead_mark = RST_NEC_LEAD;
    tick.lead_space    = RST_LEAD_SPACE;
    tick.alt_lead_mark = RST_ALT_LEAD;
    tick.bit_mark      = RST_BIT_MARK;
    tick.one_space     = RST_ONE_SPACE;
    tick.zero_space    = RST_ZERO_SPACE;
    tick.stop_mark     = RST_STOP_MARK;
    settings = 1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timings: address/command extremes, short vs extended address,
    // both protocols, alternating bit patterns
    queue_frame(16'h0000, 8'h00, 1'b0);
    queue_frame(16'h00FF, 8'hFF, 1'b0);
    queue_frame(16'h0100, 8'h00, 1'b0);
    queue_frame(16'hFFFF, 8'hFF, 1'b0);
    queue_frame(16'h0000, 8'h00, 1'b1);
    queue_frame(16'h00FF, 8'h55, 1'b1);
    queue_frame(16'hFFFF, 8'hAA, 1'b1);
    queue_frame(16'h00AA, 8'h0F, 1'b0);
    queue_frame(16'h5500, 8'hF0, 1'b0);
    queue_frame(16'hAA55, 8'h3C, 1'b1);
    queue_frame(16'h0001, 8'h80, 1'b0);
    queue_frame(16'h8000, 8'h01, 1'b0);
    drain();

    // all registers at full scale; a write to the spare index must not land
    program_regs(CFG_MAX);
    write_reg(REG_SPARE, 15'h1234);
    queue_frame(16'h00FF, 8'h00, 1'b0);
    queue_frame(16'hFF00, 8'hFF, 1'b1);
    queue_random(8);
    drain();

    program_regs(CFG_ZERO);
    queue_frame(16'h0080, 8'h7F, 1'b0);
    queue_random(9);
    drain();

    // back-to-back words with the sink held off: input must stall, not drop
    program_regs(CFG_RAND);
    in_mode     = PACE_NONE;
    out_mode    = PACE_NONE;
    squeeze_req = 1'b1;
    queue_random(30);
    drain();
    squeeze_req = 1'b0;

    for (ph = 0; ph < 6; ph++) begin
      program_regs(CFG_RAND);
      in_mode  = pace_t'(ph % 3);
      out_mode = pace_t'((ph / 3 + ph) % 3);
      queue_random(48);
      drain();
    end

    repeat (20) @(posedge clk);
    $display("%0d frames encoded, %0d symbol words checked, %0d mismatches",
             frames_in, words_out, mismatches);
    $display("%0d timing settings incl. reset, zero and full scale; sink squeeze %0s",
             settings, squeeze_done ? "done" : "missed");
    if (mismatches == 0 && frame_syms_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: ir_nec_frame_encoder.f
rtl/nfe_pkg.sv
rtl/nfe_if.sv
rtl/nfe_cfg.sv
rtl/nfe_frame.sv
rtl/nfe_symbol.sv
rtl/ir_nec_frame_encoder.sv
bench/tb_top.sv
